// File: rtl/positional_list_table_top_assert.svh
// assertion macros used by the list table datapath
`ifndef POSITIONAL_LIST_TABLE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_TABLE_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PLT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/plt_pkg.sv
package plt_pkg;

  // list geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // port field widths
  localparam int REQ_W   = 3;
  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND  = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_SWAP    = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_READ    = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RM_SHIFT,
    ST_SW_RDB,
    ST_SW_WRA,
    ST_SW_WRB,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_A,
    RD_B,
    RD_CUR
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_APPEND,
    WR_REPLACE,
    WR_SWAP_A,
    WR_SWAP_B,
    WR_SHIFT
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    err_cap;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    hold_cap;
    logic    shift_start;
    logic    shift_step;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    result_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t    op;
    status_t err;
    logic    shift_done;
    logic    out_busy;
  } sts_t;

endpackage

// File: rtl/plt_ctrl.sv
module plt_ctrl
  import plt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.err != STAT_OK) begin
          state_next = ST_FINISH;
        end else begin
          case (sts.op)
            REQ_REMOVE: state_next = ST_RM_SHIFT;
            REQ_SWAP:   state_next = ST_SW_RDB;
            REQ_READ:   state_next = ST_RD_WAIT;
            default:    state_next = ST_FINISH;
          endcase
        end
      end
      ST_RM_SHIFT: begin
        if (sts.shift_done) state_next = ST_FINISH;
      end
      ST_SW_RDB:  state_next = ST_SW_WRA;
      ST_SW_WRA:  state_next = ST_SW_WRB;
      ST_SW_WRB:  state_next = ST_FINISH;
      ST_RD_WAIT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: begin
        cmd.err_cap = 1'b1;
        if (sts.err == STAT_OK) begin
          case (sts.op)
            REQ_APPEND: begin
              cmd.wr_sel  = WR_APPEND;
              cmd.cnt_inc = 1'b1;
            end
            REQ_REMOVE:  cmd.shift_start = 1'b1;
            REQ_SWAP:    cmd.rd_sel = RD_A;
            REQ_REPLACE: cmd.wr_sel = WR_REPLACE;
            REQ_READ:    cmd.rd_sel = RD_A;
            default: ;
          endcase
        end
      end
      ST_RM_SHIFT: begin
        cmd.rd_sel = RD_CUR;
        cmd.wr_sel = WR_SHIFT;
        if (sts.shift_done) begin
          cmd.cnt_dec = 1'b1;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      ST_SW_RDB: begin
        cmd.hold_cap = 1'b1;
        cmd.rd_sel   = RD_B;
      end
      ST_SW_WRA:  cmd.wr_sel = WR_SWAP_A;
      ST_SW_WRB:  cmd.wr_sel = WR_SWAP_B;
      ST_RD_WAIT: cmd.hold_cap = 1'b1;
      ST_FINISH:  cmd.result_load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

// File: rtl/plt_dp.sv
`include "positional_list_table_top_assert.svh"

module plt_dp
  import plt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [POS_W-1:0]   position_a,
  input  logic [POS_W-1:0]   position_b,
  input  logic [WORD_W-1:0]  entry_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [COUNT_W-1:0] entry_count,
  output logic [WORD_W-1:0]  read_data
);

  // request registers
  req_t                  op;
  logic [POS_W-1:0]      pa;
  logic [POS_W-1:0]      pb;
  logic [DATA_WIDTH-1:0] wdata_req;
  status_t               err;

  // list state
  logic [CNT_W-1:0]      total;
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] hold;

  // shift cursor
  logic [CNT_W-1:0]  cur;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;

  // result register
  status_t            res_status;
  logic [CNT_W-1:0]   res_count;
  logic [WORD_W-1:0]  res_data;

  logic [POS_W-1:0]      total_pos;
  logic                  pa_ok;
  logic                  pb_ok;
  status_t               err_now;
  logic [ADDR_W-1:0]     pa_idx;
  logic [ADDR_W-1:0]     pb_idx;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  we;

  // latch the request, its check result and the held read word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= req_t'(req_type);
      pa        <= position_a;
      pb        <= position_b;
      wdata_req <= entry_data[DATA_WIDTH-1:0];
    end
    if (cmd.err_cap) err <= err_now;
    if (cmd.hold_cap) hold <= rdata;
  end

  // request checks against the current count
  assign total_pos = POS_W'(total);
  assign pa_ok     = (pa != '0) && (pa <= total_pos);
  assign pb_ok     = (pb != '0) && (pb <= total_pos);
  assign pa_idx    = ADDR_W'(pa - POS_W'(1));
  assign pb_idx    = ADDR_W'(pb - POS_W'(1));

  always_comb begin
    err_now = STAT_OK;
    case (op)
      REQ_APPEND: begin
        if (total >= CNT_W'(DEPTH)) err_now = STAT_FULL;
      end
      REQ_SWAP: begin
        if (total < CNT_W'(2)) err_now = STAT_EMPTY;
        else if (!pa_ok || !pb_ok) err_now = STAT_RANGE;
      end
      REQ_REMOVE, REQ_REPLACE, REQ_READ: begin
        if (total == '0) err_now = STAT_EMPTY;
        else if (!pa_ok) err_now = STAT_RANGE;
      end
      default: err_now = STAT_OK;
    endcase
  end

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_A:    raddr = pa_idx;
      RD_B:    raddr = pb_idx;
      RD_CUR:  raddr = cur[ADDR_W-1:0];
      default: raddr = '0;
    endcase
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = wdata_req;
    case (cmd.wr_sel)
      WR_APPEND: begin
        we    = 1'b1;
        waddr = ADDR_W'(total);
      end
      WR_REPLACE: begin
        we    = 1'b1;
        waddr = pa_idx;
      end
      WR_SWAP_A: begin
        we    = 1'b1;
        waddr = pa_idx;
        wdata = rdata;
      end
      WR_SWAP_B: begin
        we    = 1'b1;
        waddr = pb_idx;
        wdata = hold;
      end
      WR_SHIFT: begin
        we    = pend;
        waddr = pend_addr;
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // shift cursor: read at cur, write one place lower in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.shift_start) begin
      cur  <= CNT_W'(pa);
      pend <= 1'b0;
    end else if (cmd.shift_step) begin
      if (cur < total) begin
        cur       <= cur + CNT_W'(1);
        pend      <= 1'b1;
        pend_addr <= ADDR_W'(cur - CNT_W'(1));
      end else begin
        pend <= 1'b0;
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.cnt_inc) begin
      total <= total + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      total <= total - CNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      res_status <= err;
      res_count  <= total;
      if (op == REQ_READ && err == STAT_OK) begin
        res_data <= WORD_W'(hold);
      end else begin
        res_data <= '0;
      end
    end
  end

  assign status      = res_status;
  assign entry_count = COUNT_W'(res_count);
  assign read_data   = res_data;

  // status back to the controller
  assign sts.op         = op;
  assign sts.err        = err_now;
  assign sts.shift_done = (cur == total) && !pend;
  assign sts.out_busy   = out_valid && !out_ready;

  `PLT_ASSERT_SAME(a_count_max, 1'b1, total <= CNT_W'(DEPTH), "entry count above depth")
  `PLT_ASSERT_SAME(a_append_room, cmd.wr_sel == WR_APPEND, total < CNT_W'(DEPTH), "append when full")
  `PLT_ASSERT_SAME(a_count_one_way, cmd.cnt_inc, !cmd.cnt_dec, "count up and down together")
  `PLT_ASSERT_NEXT(a_result_shown, cmd.result_load, out_valid, "result not presented")
  `PLT_ASSERT_SAME(a_no_overwrite, cmd.result_load, !out_valid || out_ready, "result overwritten")

endmodule

// File: rtl/positional_list_table_top.sv
// Positional list table: an ordered list of up to 64 words addressed by
// 1-based position, with append, remove (later entries move down one
// place), swap, replace and read requests.
// Input channel in_valid/in_ready carries one request per transaction
// (req_type, position_a, position_b, entry_data); output channel
// out_valid/out_ready returns one result per request (status,
// entry_count, read_data) in request order.
// Append, replace, rejected and unknown requests finish right after
// their check; a read first waits for its registered memory read, a
// swap reads both entries and writes them back in turn, and a remove
// walks the single entry memory, moving one word per cycle through its
// one read and one write port. One request is in work at a time; the
// next one can be taken in the cycle its result turns valid. in_ready
// is high while the block is idle, also while a finished result still
// waits in the output register. A stalled receiver holds the result in
// that register; the next request runs up to its result and then waits
// until it is free.
// Synchronous reset empties the list and drops any pending result.
module positional_list_table_top
  import plt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [POS_W-1:0]   position_a,
  input  logic [POS_W-1:0]   position_b,
  input  logic [WORD_W-1:0]  entry_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [COUNT_W-1:0] entry_count,
  output logic [WORD_W-1:0]  read_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  plt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // list storage and result path
  plt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .position_a  (position_a),
    .position_b  (position_b),
    .entry_data  (entry_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_count (entry_count),
    .read_data   (read_data)
  );

endmodule
